[src/rud_pkg.sv]
// ----------------------------------------------------------------------------
// rud_pkg: shared definitions for the restoring unsigned divider
// Holds the fixed width of the operand and result ports.
// ----------------------------------------------------------------------------
package rud_pkg;

    // width of every payload port, independent of the datapath width
    localparam int DATA_W = 32;

    typedef logic [DATA_W-1:0] t_data;

endpackage : rud_pkg

[src/rud_cell.sv]
// ----------------------------------------------------------------------------
// rud_cell: one round of restoring division
// Shifts the partial remainder and quotient left, trial-subtracts the
// divisor and registers the restored or reduced remainder for the next cell.
// ----------------------------------------------------------------------------
module rud_cell #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_acc,
    input  logic [WIDTH-1:0] i_quo,
    input  logic [WIDTH-1:0] i_dvs,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_acc,
    output logic [WIDTH-1:0] o_quo,
    output logic [WIDTH-1:0] o_dvs
);

    logic             r_valid, n_valid;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_dvs, n_dvs;

    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_diff;
    logic             w_fits;

    // shift in the quotient's top bit and trial-subtract the divisor;
    // a carry out of the shift or no borrow means the divisor fits
    assign w_shift = {i_acc, i_quo[WIDTH-1]};
    assign w_diff  = {1'b0, w_shift[WIDTH-1:0]} - {1'b0, i_dvs};
    assign w_fits  = w_shift[WIDTH] | ~w_diff[WIDTH];

    // keep the difference on success, restore otherwise
    always_comb begin
        n_valid = i_valid;
        n_dvs   = i_dvs;
        if (w_fits) begin
            n_acc = w_diff[WIDTH-1:0];
            n_quo = {i_quo[WIDTH-2:0], 1'b1};
        end else begin
            n_acc = w_shift[WIDTH-1:0];
            n_quo = {i_quo[WIDTH-2:0], 1'b0};
        end
    end

    // advance the valid marker; clear it on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // advance the request payload
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_quo   = r_quo;
    assign o_dvs   = r_dvs;

endmodule : rud_cell

[src/restoring_unsigned_divider_core.sv]
// o_done strobes once an accepted start has passed through the registers of all WIDTH cells.
// Throughput: one request per cycle; busy stays low, the receiver cannot stall.
// Each of the WIDTH cells in the chain resolves one quotient bit per cycle.
// Reset (synchronous, active low) drops every request in flight; no strobe
// follows until new requests arrive.
// ----------------------------------------------------------------------------
// restoring_unsigned_divider_core: pipelined restoring unsigned divider
// A chain of WIDTH division cells returns quotient and remainder. A zero
// divisor yields an all-ones quotient and the dividend as remainder.
// ----------------------------------------------------------------------------
module restoring_unsigned_divider_core
    import rud_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_data i_dividend,
    input  t_data i_divisor,
    output logic  o_done,
    output t_data o_quotient,
    output t_data o_remainder
);

    logic             w_valid [0:WIDTH];
    logic [WIDTH-1:0] w_acc   [0:WIDTH];
    logic [WIDTH-1:0] w_quo   [0:WIDTH];
    logic [WIDTH-1:0] w_dvs   [0:WIDTH];

    // never hold off a request
    assign busy = 1'b0;

    // feed the first cell from the ports, fitted to the datapath width
    assign w_valid[0] = start;
    assign w_acc[0]   = '0;
    assign w_quo[0]   = WIDTH'(i_dividend);
    assign w_dvs[0]   = WIDTH'(i_divisor);

    // build the chain, one cell per quotient bit
    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        rud_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_acc   (w_acc[g]),
            .i_quo   (w_quo[g]),
            .i_dvs   (w_dvs[g]),
            .o_valid (w_valid[g+1]),
            .o_acc   (w_acc[g+1]),
            .o_quo   (w_quo[g+1]),
            .o_dvs   (w_dvs[g+1])
        );
    end

    // drive the results from the last cell
    assign o_done      = w_valid[WIDTH];
    assign o_quotient  = DATA_W'(w_quo[WIDTH]);
    assign o_remainder = DATA_W'(w_acc[WIDTH]);

`ifndef ASSERT_OFF
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, WIDTH))
        else $error("result strobe without a request WIDTH cycles earlier");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (w_dvs[WIDTH] != '0)) |-> (w_acc[WIDTH] < w_dvs[WIDTH]))
        else $error("remainder not below nonzero divisor");

    a_zero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (w_dvs[WIDTH] == '0)) |-> (w_quo[WIDTH] == '1))
        else $error("zero divisor did not give all-ones quotient");
`endif

endmodule : restoring_unsigned_divider_core

[sim/restoring_unsigned_divider_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// restoring_unsigned_divider_core_tb: self-checking bench for the divider
// Runs a table of directed operand pairs, then about two thousand random
// requests under three sender idle profiles. A local bit-serial restoring
// divider predicts quotient and remainder. Results are matched in order.
// ----------------------------------------------------------------------------
module restoring_unsigned_divider_core_tb
    import rud_pkg::*;
();

    localparam int W            = 32;
    localparam int STALL_LIMIT  = 2000;
    localparam int N_DIRECTED   = 18;
    localparam int N_PER_PHASE  = 667;
    localparam t_data ALL_ONES  = '1;

    typedef struct packed {
        t_data quotient;
        t_data remainder;
    } t_quot_rem;

    typedef struct packed {
        t_data     num;
        t_data     den;
        bit        typed;
        t_quot_rem res;
    } t_div_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_data dividend;
    t_data divisor;
    logic  done;
    t_data quotient;
    t_data remainder;

    t_quot_rem pending_results[$];
    int        error_count  = 0;
    int        stall_cycles = 0;

    // operand pairs; typed results are those obvious from the arithmetic
    t_div_row directed_rows [N_DIRECTED] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, '{ALL_ONES,     32'h0000_0000}},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ALL_ONES,     32'hFFFF_FFFF}},
        '{32'h1234_5678, 32'h0000_0000, 1'b1, '{ALL_ONES,     32'h1234_5678}},
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 32'h0000_0000}},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'h0000_0000}},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0001, 32'h0000_0000}},
        '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'h0000_0001}},
        '{32'hFFFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0000_0001, 32'h7FFF_FFFF}},
        '{32'h8000_0000, 32'h8000_0000, 1'b1, '{32'h0000_0001, 32'h0000_0000}},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0000_0000, 32'h7FFF_FFFF}},
        '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'hFFFF_FFFE}},
        '{32'hFFFF_FFFF, 32'h0000_0002, 1'b1, '{32'h7FFF_FFFF, 32'h0000_0001}},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, '{32'h0000_0002, 32'h0000_0000}},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, '{32'h0000_0000, 32'h5555_5555}},
        '{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h0000_0001, 32'h0000_0000}},
        '{32'h1234_5678, 32'h0000_9ABC, 1'b0, '0},
        '{32'hDEAD_BEEF, 32'hC000_0001, 1'b0, '0},
        '{32'h8000_0000, 32'h0000_0003, 1'b0, '0}
    };

    restoring_unsigned_divider_core #(
        .WIDTH(W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (done),
        .o_quotient (quotient),
        .o_remainder(remainder)
    );

    // free-running 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // bit-serial restoring division with a carry bit above the accumulator
    function automatic t_quot_rem divide_restoring(t_data num, t_data den);
        logic [W-1:0] q;
        logic [W-1:0] d;
        logic [W-1:0] acc;
        logic         carry;
        t_quot_rem    res;
        q   = num[W-1:0];
        d   = den[W-1:0];
        acc = '0;
        for (int step_i = 0; step_i < W; step_i++) begin
            carry = acc[W-1];
            acc   = {acc[W-2:0], q[W-1]};
            q     = q << 1;
            if (carry || acc >= d) begin
                acc  = acc - d;
                q[0] = 1'b1;
            end
        end
        res.quotient  = t_data'(q);
        res.remainder = t_data'(acc);
        return res;
    endfunction

    // operand mix: full random, tiny, top bit set, shifted down, extremes, ANDed pairs
    function automatic t_data pick_operand();
        case ($urandom_range(7))
            0, 1, 2: return t_data'($urandom);
            3:       return t_data'($urandom_range(15));
            4:       return {1'b1, 31'($urandom)};
            5:       return t_data'($urandom) >> $urandom_range(31);
            6: begin
                case ($urandom_range(4))
                    0:       return '0;
                    1:       return ALL_ONES;
                    2:       return 32'h8000_0000;
                    3:       return 32'h7FFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            default: return t_data'($urandom & $urandom);
        endcase
    endfunction

    // drive one request, hold it until accepted, then record its result
    task automatic send_request(t_data num, t_data den, bit typed, t_quot_rem typed_res);
        start    <= 1'b1;
        dividend <= num;
        divisor  <= den;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(typed ? typed_res : divide_restoring(num, den));
    endtask

    // drop start for a random idle stretch
    task automatic hold_off(int pct);
        int n;
        n = 0;
        while ($urandom_range(99) < pct && n < 40) n++;
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // pause the sender until every outstanding request has returned
    task automatic drain_requests();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        t_data num;
        t_data den;
        int    idle_pct;
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        dividend <= '0;
        divisor  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, back to back
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].num, directed_rows[i].den,
                         directed_rows[i].typed, directed_rows[i].res);
        end
        drain_requests();

        // random phases: sender idles 38%, then 62%, then never
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 38 : (phase == 1) ? 62 : 0;
            for (int i = 0; i < N_PER_PHASE; i++) begin
                if (i > 0) hold_off(idle_pct);
                num = pick_operand();
                case ($urandom_range(39))
                    0:       den = '0;
                    1, 2:    den = num;
                    default: den = pick_operand();
                endcase
                send_request(num, den, 1'b0, '0);
            end
            drain_requests();
        end

        // let any stray strobe show up before the verdict
        repeat (W + 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // check each result strobe against the oldest pending request
    always @(posedge i_clk) begin : check_results
        t_quot_rem want;
        if ((start && !busy) || done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (done) begin
            if (pending_results.size() == 0) begin
                $error("result strobe with no pending request: quotient %h remainder %h",
                       quotient, remainder);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (quotient !== want.quotient) begin
                    $error("quotient: expected %h, got %h", want.quotient, quotient);
                    error_count++;
                end
                if (remainder !== want.remainder) begin
                    $error("remainder: expected %h, got %h", want.remainder, remainder);
                    error_count++;
                end
            end
        end
    end

endmodule : restoring_unsigned_divider_core_tb
